// ----- hw/rtl/multi_voice_sample_mixer_macros.svh -----
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer assertion macros
// concurrent assertion shorthands shared by the checker
// ----------------------------------------------------------------------------
`ifndef MULTI_VOICE_SAMPLE_MIXER_MACROS_SVH
`define MULTI_VOICE_SAMPLE_MIXER_MACROS_SVH

// same-cycle implication
`define MVSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MVSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mvsm_pkg.sv -----
// ----------------------------------------------------------------------------
// mvsm_pkg
// shared sizes, types and codes of the multi-voice sample mixer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mvsm_pkg;

    localparam int SAMPLE_WORDS   = 262144;
    localparam int EFFECT_VOICES  = 64;
    localparam int SPEAKER_VOICES = 8;
    localparam int ALL_VOICES     = EFFECT_VOICES + SPEAKER_VOICES;

    localparam int SA_W    = $clog2(SAMPLE_WORDS);
    localparam int VA_W    = $clog2(ALL_VOICES);
    localparam int IDX_W   = $clog2(ALL_VOICES + 2);
    localparam int START_W = 18;
    localparam int FRAME_W = 19;
    localparam int STEP_W  = 24;
    localparam int FRAC_W  = 16;
    localparam int POS_W   = FRAME_W + FRAC_W;
    localparam int GAIN_W  = 9;
    localparam int SAMP_W  = 16;
    localparam int PROD_W  = SAMP_W + GAIN_W + 1;
    localparam int ACC_W   = 32;
    localparam int OUT_W   = 24;
    localparam int DECIM_W = 3;

    typedef enum logic [3:0] {
        CMD_TICK          = 4'd0,
        CMD_WRITE_SAMPLE  = 4'd1,
        CMD_START_EFFECT  = 4'd2,
        CMD_STOP_EFFECT   = 4'd3,
        CMD_START_SPEAKER = 4'd4,
        CMD_STOP_SPEAKER  = 4'd5,
        CMD_SET_LOOP      = 4'd6,
        CMD_START_MUSIC   = 4'd7,
        CMD_STOP_MUSIC    = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_MUSIC_GAIN   = 3'd0,
        CFG_EFFECT_GAIN  = 3'd1,
        CFG_SPEAKER_GAIN = 3'd2,
        CFG_DECIMATE     = 3'd3,
        CFG_STOP_MUSIC   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [FRAME_W-1:0] frames;
        logic               stereo;
        logic [STEP_W-1:0]  step;
    } region_t;

    typedef struct packed {
        region_t            rgn;
        logic [POS_W-1:0]   pos;
    } voice_rec_t;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
        lo = -ACC_W'(64'sd1 <<< (OUT_W - 1));
        if (v > hi)
        begin
            return OUT_W'(hi);
        end
        else if (v < lo)
        begin
            return OUT_W'(lo);
        end
        return OUT_W'(v);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/multi_voice_sample_mixer.sv -----
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// 64 effect voices, 8 speaker voices and a music player mixed to stereo
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Sample writes and
// speaker, loop and music commands finish in the cycle they are taken. A tick
// walks all 72 voice slots and the music player: an idle slot gets only the
// slot check, a sounding one the slot check, address, left and right reads from
// the single sample memory port. The frame appears on left_sum/right_sum with
// result_valid high for exactly one cycle, in the same cycle that busy falls;
// the receiver cannot stall it.
// Start effect scans the effect slots one per cycle; stop effect reads the
// table for each active effect slot and compares its region start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_voice_sample_mixer
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [3:0]                            command,
    input  wire logic [2:0]                            voice_index,
    input  wire logic [17:0]                           mem_address,
    input  wire logic signed [mvsm_pkg::SAMP_W-1:0]    sample_value,
    input  wire logic [mvsm_pkg::START_W-1:0]          region_start,
    input  wire logic [mvsm_pkg::FRAME_W-1:0]          region_frames,
    input  wire logic                                  region_stereo,
    input  wire logic [mvsm_pkg::STEP_W-1:0]           rate_step,
    input  wire logic                                  has_intro,
    input  wire logic                                  cfg_write,
    input  wire logic [2:0]                            cfg_index,
    input  wire logic [mvsm_pkg::GAIN_W-1:0]           cfg_data,
    output logic                                       result_valid,
    output logic signed [mvsm_pkg::OUT_W-1:0]          left_sum,
    output logic signed [mvsm_pkg::OUT_W-1:0]          right_sum
);
    import mvsm_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_FETCH   = 9'b000000010,
        S_ADDR    = 9'b000000100,
        S_LEFT    = 9'b000001000,
        S_RIGHT   = 9'b000010000,
        S_OUT     = 9'b000100000,
        S_SE_FIND = 9'b001000000,
        S_ST_RD   = 9'b010000000,
        S_ST_CMP  = 9'b100000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [ALL_VOICES-1:0]     active_reg, active_next;
    logic signed [ACC_W-1:0]   acc_l_reg, acc_l_next, acc_r_reg, acc_r_next;
    logic signed [PROD_W-1:0]  prod_l_reg, prod_l_next, prod_r_reg, prod_r_next;
    logic                      pend_reg, pend_next;
    voice_rec_t                cur_reg, cur_next;
    logic [GAIN_W-1:0]         gain_reg, gain_next;
    logic [SA_W-1:0]           addr_r_reg, addr_r_next;
    region_t                   lat_reg, lat_next;
    logic                      mus_active_reg, mus_active_next;
    logic                      mus_loop_reg, mus_loop_next;
    region_t                   intro_reg, intro_next, loop_reg, loop_next;
    logic [POS_W-1:0]          mus_pos_reg, mus_pos_next;
    logic                      valid_reg, valid_next;
    logic signed [OUT_W-1:0]   left_reg, left_next, right_reg, right_next;

    logic [GAIN_W-1:0]         music_gain_reg, effect_gain_reg, speaker_gain_reg;
    logic                      decimate_reg, stop_end_reg;

    logic                      vm_we;
    logic [VA_W-1:0]           vm_waddr;
    voice_rec_t                vm_wdata, vm_rdata;
    logic                      sm_we;
    logic [SA_W-1:0]           sm_raddr;
    logic signed [SAMP_W-1:0]  sm_rdata;

    logic                      accept;
    logic                      is_music;
    logic [VA_W-1:0]           vidx;
    logic [VA_W-1:0]           spk_addr;
    voice_rec_t                cur_src;
    logic [FRAME_W-1:0]        frame;
    logic [FRAME_W:0]          offset;
    logic [SA_W-1:0]           addr_l;
    logic [POS_W-1:0]          new_pos;
    logic                      ended;
    region_t                   in_rgn;

    assign accept   = start && (state_reg == S_IDLE);
    assign busy     = (state_reg != S_IDLE);
    assign is_music = (idx_reg == IDX_W'(ALL_VOICES));
    assign vidx     = idx_reg[VA_W-1:0];
    assign spk_addr = VA_W'(EFFECT_VOICES) + VA_W'(voice_index);
    assign in_rgn   = '{start: region_start, frames: region_frames,
                        stereo: region_stereo, step: rate_step};

    assign result_valid = valid_reg;
    assign left_sum     = left_reg;
    assign right_sum    = right_reg;

    mvsm_sample_mem u_sample_mem
    (
        .clk   (clk),
        .we    (sm_we),
        .waddr (SA_W'(mem_address)),
        .wdata (sample_value),
        .raddr (sm_raddr),
        .rdata (sm_rdata)
    );

    mvsm_voice_mem u_voice_mem
    (
        .clk   (clk),
        .we    (vm_we),
        .waddr (vm_waddr),
        .wdata (vm_wdata),
        .raddr (vidx),
        .rdata (vm_rdata)
    );

    // frame address of the current source
    always_comb
    begin
        if (is_music)
        begin
            cur_src = '{rgn: (mus_loop_reg ? loop_reg : intro_reg), pos: mus_pos_reg};
        end
        else
        begin
            cur_src = vm_rdata;
        end
        frame = cur_src.pos[POS_W-1:FRAC_W];
        if (decimate_reg && !is_music)
        begin
            frame[DECIM_W-1:0] = '0;
        end
        offset = cur_src.rgn.stereo ? {frame, 1'b0} : {1'b0, frame};
        addr_l = SA_W'(cur_src.rgn.start) + SA_W'(offset);
        new_pos = cur_reg.pos + POS_W'(cur_reg.rgn.step);
        ended   = (new_pos[POS_W-1:FRAC_W] >= cur_reg.rgn.frames);
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        active_next     = active_reg;
        acc_l_next      = acc_l_reg;
        acc_r_next      = acc_r_reg;
        prod_l_next     = prod_l_reg;
        prod_r_next     = prod_r_reg;
        pend_next       = 1'b0;
        cur_next        = cur_reg;
        gain_next       = gain_reg;
        addr_r_next     = addr_r_reg;
        lat_next        = lat_reg;
        mus_active_next = mus_active_reg;
        mus_loop_next   = mus_loop_reg;
        intro_next      = intro_reg;
        loop_next       = loop_reg;
        mus_pos_next    = mus_pos_reg;
        valid_next      = 1'b0;
        left_next       = left_reg;
        right_next      = right_reg;
        vm_we           = 1'b0;
        vm_waddr        = vidx;
        vm_wdata        = '{rgn: lat_reg, pos: '0};
        sm_we           = 1'b0;
        sm_raddr        = addr_l;

        // products from the last right read join the sums
        if (pend_reg)
        begin
            acc_l_next = acc_l_reg + ACC_W'(prod_l_reg);
            acc_r_next = acc_r_reg + ACC_W'(prod_r_reg);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_TICK:
                        begin
                            idx_next   = '0;
                            acc_l_next = '0;
                            acc_r_next = '0;
                            state_next = S_FETCH;
                        end
                        CMD_WRITE_SAMPLE:
                        begin
                            sm_we = 1'b1;
                        end
                        CMD_START_EFFECT:
                        begin
                            lat_next   = in_rgn;
                            idx_next   = '0;
                            state_next = S_SE_FIND;
                        end
                        CMD_STOP_EFFECT:
                        begin
                            lat_next   = in_rgn;
                            idx_next   = '0;
                            state_next = S_ST_RD;
                        end
                        CMD_START_SPEAKER:
                        begin
                            if (int'(voice_index) < SPEAKER_VOICES)
                            begin
                                vm_we                 = 1'b1;
                                vm_waddr              = spk_addr;
                                vm_wdata              = '{rgn: in_rgn, pos: '0};
                                active_next[spk_addr] = 1'b1;
                            end
                        end
                        CMD_STOP_SPEAKER:
                        begin
                            if (int'(voice_index) < SPEAKER_VOICES)
                            begin
                                active_next[spk_addr] = 1'b0;
                            end
                        end
                        CMD_SET_LOOP:
                        begin
                            loop_next = in_rgn;
                        end
                        CMD_START_MUSIC:
                        begin
                            if (has_intro)
                            begin
                                intro_next    = in_rgn;
                                mus_loop_next = 1'b0;
                            end
                            else
                            begin
                                mus_loop_next = 1'b1;
                            end
                            mus_active_next = 1'b1;
                            mus_pos_next    = '0;
                        end
                        CMD_STOP_MUSIC:
                        begin
                            mus_active_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                if (is_music)
                begin
                    state_next = mus_active_reg ? S_ADDR : S_OUT;
                end
                else if (idx_reg > IDX_W'(ALL_VOICES))
                begin
                    state_next = S_OUT;
                end
                else if (active_reg[vidx])
                begin
                    state_next = S_ADDR;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_ADDR:
            begin
                cur_next    = cur_src;
                addr_r_next = cur_src.rgn.stereo ? addr_l + SA_W'(1) : addr_l;
                if (is_music)
                begin
                    gain_next = music_gain_reg;
                end
                else if (int'(vidx) < EFFECT_VOICES)
                begin
                    gain_next = effect_gain_reg;
                end
                else
                begin
                    gain_next = speaker_gain_reg;
                end
                state_next = S_LEFT;
            end
            S_LEFT:
            begin
                prod_l_next = PROD_W'(sm_rdata * $signed({1'b0, gain_reg}));
                sm_raddr    = addr_r_reg;
                state_next  = S_RIGHT;
            end
            S_RIGHT:
            begin
                prod_r_next = PROD_W'(sm_rdata * $signed({1'b0, gain_reg}));
                pend_next   = 1'b1;
                if (is_music)
                begin
                    if (ended)
                    begin
                        if (stop_end_reg)
                        begin
                            mus_active_next = 1'b0;
                        end
                        else
                        begin
                            mus_loop_next = 1'b1;
                        end
                        mus_pos_next = '0;
                    end
                    else
                    begin
                        mus_pos_next = new_pos;
                    end
                end
                else
                begin
                    vm_we    = 1'b1;
                    vm_wdata = '{rgn: cur_reg.rgn, pos: new_pos};
                    if (ended)
                    begin
                        active_next[vidx] = 1'b0;
                    end
                end
                idx_next   = idx_reg + IDX_W'(1);
                state_next = S_FETCH;
            end
            S_OUT:
            begin
                left_next  = sat_out(acc_l_reg);
                right_next = sat_out(acc_r_reg);
                valid_next = 1'b1;
                state_next = S_IDLE;
            end
            S_SE_FIND:
            begin
                if (!active_reg[vidx])
                begin
                    vm_we             = 1'b1;
                    active_next[vidx] = 1'b1;
                    state_next        = S_IDLE;
                end
                else if (idx_reg == IDX_W'(EFFECT_VOICES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_ST_RD:
            begin
                if (active_reg[vidx])
                begin
                    state_next = S_ST_CMP;
                end
                else if (idx_reg == IDX_W'(EFFECT_VOICES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_ST_CMP:
            begin
                if (vm_rdata.rgn.start == lat_reg.start)
                begin
                    active_next[vidx] = 1'b0;
                    state_next        = S_IDLE;
                end
                else if (idx_reg == IDX_W'(EFFECT_VOICES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_ST_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            active_reg     <= '0;
            pend_reg       <= 1'b0;
            mus_active_reg <= 1'b0;
            mus_loop_reg   <= 1'b0;
            intro_reg      <= '0;
            loop_reg       <= '0;
            mus_pos_reg    <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            active_reg     <= active_next;
            pend_reg       <= pend_next;
            mus_active_reg <= mus_active_next;
            mus_loop_reg   <= mus_loop_next;
            intro_reg      <= intro_next;
            loop_reg       <= loop_next;
            mus_pos_reg    <= mus_pos_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_l_reg  <= acc_l_next;
        acc_r_reg  <= acc_r_next;
        prod_l_reg <= prod_l_next;
        prod_r_reg <= prod_r_next;
        cur_reg    <= cur_next;
        gain_reg   <= gain_next;
        addr_r_reg <= addr_r_next;
        lat_reg    <= lat_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            music_gain_reg   <= GAIN_W'(128);
            effect_gain_reg  <= GAIN_W'(256);
            speaker_gain_reg <= GAIN_W'(256);
            decimate_reg     <= 1'b0;
            stop_end_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MUSIC_GAIN:   music_gain_reg   <= cfg_data;
                CFG_EFFECT_GAIN:  effect_gain_reg  <= cfg_data;
                CFG_SPEAKER_GAIN: speaker_gain_reg <= cfg_data;
                CFG_DECIMATE:     decimate_reg     <= cfg_data[0];
                CFG_STOP_MUSIC:   stop_end_reg     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mvsm_sample_mem.sv -----
// ----------------------------------------------------------------------------
// mvsm_sample_mem
// shared sample word memory, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvsm_sample_mem
(
    input  wire logic                               clk,
    input  wire logic                               we,
    input  wire logic [mvsm_pkg::SA_W-1:0]          waddr,
    input  wire logic signed [mvsm_pkg::SAMP_W-1:0] wdata,
    input  wire logic [mvsm_pkg::SA_W-1:0]          raddr,
    output logic signed [mvsm_pkg::SAMP_W-1:0]      rdata
);
    import mvsm_pkg::*;

    logic signed [SAMP_W-1:0] mem [SAMPLE_WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mvsm_voice_mem.sv -----
// ----------------------------------------------------------------------------
// mvsm_voice_mem
// per-voice region and position table, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvsm_voice_mem
(
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [mvsm_pkg::VA_W-1:0]    waddr,
    input  wire mvsm_pkg::voice_rec_t         wdata,
    input  wire logic [mvsm_pkg::VA_W-1:0]    raddr,
    output mvsm_pkg::voice_rec_t              rdata
);
    import mvsm_pkg::*;

    voice_rec_t mem [ALL_VOICES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mvsm_checker.sv -----
// ----------------------------------------------------------------------------
// mvsm_checker
// port-level checks of the mixer command and result timing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multi_voice_sample_mixer_macros.svh"

module mvsm_checker
(
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  start,
    input wire logic                                  busy,
    input wire logic [3:0]                            command,
    input wire logic                                  result_valid,
    input wire logic signed [mvsm_pkg::OUT_W-1:0]     left_sum,
    input wire logic signed [mvsm_pkg::OUT_W-1:0]     right_sum
);
    import mvsm_pkg::*;

    logic tick_taken;
    logic other_taken;

    assign tick_taken  = start && !busy && (command == CMD_TICK);
    assign other_taken = start && !busy && (command != CMD_TICK);

    `MVSM_ASSERT_NEXT(a_strobe_single, clk, rst_n, result_valid, !result_valid, "result strobe longer than one cycle")
    `MVSM_ASSERT_NEXT(a_tick_busy, clk, rst_n, tick_taken, busy && !result_valid, "tick transfer did not start a mix pass")
    `MVSM_ASSERT_NOW(a_result_idle, clk, rst_n, result_valid, !busy, "result shown while still busy")
    `MVSM_ASSERT_NEXT(a_no_spurious, clk, rst_n, other_taken, !result_valid, "result after a non-tick transfer")
    `MVSM_ASSERT_NOW(a_result_known, clk, rst_n, result_valid, !$isunknown({left_sum, right_sum}), "unknown frame")

endmodule

bind multi_voice_sample_mixer mvsm_checker u_mvsm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .result_valid (result_valid),
    .left_sum     (left_sum),
    .right_sum    (right_sum)
);

`default_nettype wire

// ----- tb/sv/multi_voice_sample_mixer_tb.sv -----
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer_tb
// self-checking bench for the multi-voice sample mixer: a directed table of
// commands, then weighted random command streams under several gain, decimate
// and music-end settings, each stereo frame compared with a local mixer model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_voice_sample_mixer_tb;

    import mvsm_pkg::*;

    localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
    localparam int WRAP_BASE  = SAMPLE_WORDS - 64;
    localparam int LOW_WORDS  = 512;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 400;

    typedef struct {
        logic [3:0]         cmd;
        logic [2:0]         vidx;
        logic [17:0]        addr;
        logic signed [15:0] sval;
        region_t            rgn;
        logic               intro;
    } mix_cmd_t;

    typedef struct {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
    } frame_t;

    typedef struct {
        mix_cmd_t c;
        bit       known;
        int       left;
        int       right;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [3:0] command = '0;
    logic [2:0] voice_index = '0;
    logic [17:0] mem_address = '0;
    logic signed [SAMP_W-1:0] sample_value = '0;
    logic [START_W-1:0] region_start = '0;
    logic [FRAME_W-1:0] region_frames = '0;
    logic region_stereo = 1'b0;
    logic [STEP_W-1:0] rate_step = '0;
    logic has_intro = 1'b0;
    logic cfg_write = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [GAIN_W-1:0] cfg_data = '0;
    logic result_valid;
    logic signed [OUT_W-1:0] left_sum;
    logic signed [OUT_W-1:0] right_sum;

    // mixer model state
    logic signed [15:0] pcm_mem [0:SAMPLE_WORDS-1];
    bit                 voice_on [0:ALL_VOICES-1];
    region_t            voice_rgn [0:ALL_VOICES-1];
    logic [POS_W-1:0]   voice_pos [0:ALL_VOICES-1];
    bit                 music_on;
    bit                 music_looping;
    region_t            intro_rgn;
    region_t            loop_rgn;
    logic [POS_W-1:0]   music_pos;
    int unsigned        gain_music;
    int unsigned        gain_effect;
    int unsigned        gain_speaker;
    bit                 decim_on;
    bit                 music_stop_end;

    frame_t      frames_due[$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          no_idle = 1'b0;

    always #5 clk = ~clk;

    multi_voice_sample_mixer uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .voice_index  (voice_index),
        .mem_address  (mem_address),
        .sample_value (sample_value),
        .region_start (region_start),
        .region_frames(region_frames),
        .region_stereo(region_stereo),
        .rate_step    (rate_step),
        .has_intro    (has_intro),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .left_sum     (left_sum),
        .right_sum    (right_sum)
    );

    function automatic longint word_at(region_t g, longint frame, int ch);
        longint off;
        off = g.stereo ? frame * 2 + ch : frame;
        return longint'(pcm_mem[(longint'(g.start) + off) % SAMPLE_WORDS]);
    endfunction

    function automatic logic signed [OUT_W-1:0] clip24(longint v);
        if (v > 8388607)
        begin
            return 24'sh7FFFFF;
        end
        if (v < -8388608)
        begin
            return 24'sh800000;
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic void model_reset();
        for (int i = 0; i < ALL_VOICES; i++)
        begin
            voice_on[i] = 1'b0;
            voice_rgn[i] = '0;
            voice_pos[i] = '0;
        end
        music_on = 1'b0;
        music_looping = 1'b0;
        intro_rgn = '0;
        loop_rgn = '0;
        music_pos = '0;
        gain_music = 128;
        gain_effect = 256;
        gain_speaker = 256;
        decim_on = 1'b0;
        music_stop_end = 1'b0;
    endfunction

    // one output frame: mixes everything and advances every sounding position
    function automatic frame_t mix_frame();
        longint l;
        longint r;
        longint fr;
        longint g;
        region_t m;
        frame_t f;
        l = 0;
        r = 0;
        if (music_on)
        begin
            m = music_looping ? loop_rgn : intro_rgn;
            fr = longint'(music_pos >> FRAC_W);
            l += word_at(m, fr, 0) * gain_music;
            r += word_at(m, fr, m.stereo ? 1 : 0) * gain_music;
            music_pos = music_pos + m.step;
            if (longint'(music_pos >> FRAC_W) >= longint'(m.frames))
            begin
                if (music_stop_end)
                begin
                    music_on = 1'b0;
                end
                else
                begin
                    music_looping = 1'b1;
                    music_pos = '0;
                end
            end
        end
        for (int i = 0; i < ALL_VOICES; i++)
        begin
            if (voice_on[i])
            begin
                g = (i < EFFECT_VOICES) ? gain_effect : gain_speaker;
                fr = longint'(voice_pos[i] >> FRAC_W);
                if (decim_on)
                begin
                    fr = fr & ~longint'(7);
                end
                l += word_at(voice_rgn[i], fr, 0) * g;
                r += word_at(voice_rgn[i], fr, voice_rgn[i].stereo ? 1 : 0) * g;
                voice_pos[i] = voice_pos[i] + voice_rgn[i].step;
                if (longint'(voice_pos[i] >> FRAC_W) >= longint'(voice_rgn[i].frames))
                begin
                    voice_on[i] = 1'b0;
                end
            end
        end
        f.left = clip24(l);
        f.right = clip24(r);
        return f;
    endfunction

    function automatic void model_command(mix_cmd_t c);
        bit found;
        found = 1'b0;
        case (c.cmd)
            CMD_TICK:
            begin
                frames_due.push_back(mix_frame());
            end
            CMD_WRITE_SAMPLE:
            begin
                pcm_mem[c.addr] = c.sval;
            end
            CMD_START_EFFECT:
            begin
                for (int i = 0; i < EFFECT_VOICES; i++)
                begin
                    if (!found && !voice_on[i])
                    begin
                        voice_on[i] = 1'b1;
                        voice_rgn[i] = c.rgn;
                        voice_pos[i] = '0;
                        found = 1'b1;
                    end
                end
            end
            CMD_STOP_EFFECT:
            begin
                for (int i = 0; i < EFFECT_VOICES; i++)
                begin
                    if (!found && voice_on[i] && voice_rgn[i].start == c.rgn.start)
                    begin
                        voice_on[i] = 1'b0;
                        found = 1'b1;
                    end
                end
            end
            CMD_START_SPEAKER:
            begin
                if (c.vidx < SPEAKER_VOICES)
                begin
                    voice_on[EFFECT_VOICES + c.vidx] = 1'b1;
                    voice_rgn[EFFECT_VOICES + c.vidx] = c.rgn;
                    voice_pos[EFFECT_VOICES + c.vidx] = '0;
                end
            end
            CMD_STOP_SPEAKER:
            begin
                if (c.vidx < SPEAKER_VOICES)
                begin
                    voice_on[EFFECT_VOICES + c.vidx] = 1'b0;
                end
            end
            CMD_SET_LOOP:
            begin
                loop_rgn = c.rgn;
            end
            CMD_START_MUSIC:
            begin
                if (c.intro)
                begin
                    intro_rgn = c.rgn;
                    music_looping = 1'b0;
                end
                else
                begin
                    music_looping = 1'b1;
                end
                music_on = 1'b1;
                music_pos = '0;
            end
            CMD_STOP_MUSIC:
            begin
                music_on = 1'b0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic mix_cmd_t mk(logic [3:0] cmd, int start_w, int frames, bit stereo,
                                     int step);
        mix_cmd_t c;
        c.cmd = cmd;
        c.vidx = '0;
        c.addr = '0;
        c.sval = '0;
        c.rgn.start = start_w[17:0];
        c.rgn.frames = frames[18:0];
        c.rgn.stereo = stereo;
        c.rgn.step = step[23:0];
        c.intro = 1'b0;
        return c;
    endfunction

    // regions stay inside the prefilled words so no unwritten word is read
    function automatic region_t rand_region();
        region_t g;
        if ($urandom_range(0, 99) < 15)
        begin
            g.start = START_W'(WRAP_BASE + $urandom_range(0, 63));
        end
        else
        begin
            g.start = START_W'($urandom_range(0, 15) * 16);
        end
        g.frames = FRAME_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8)
                                                        : $urandom_range(0, 127));
        g.stereo = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: g.step = STEP_W'($urandom);
            1: g.step = STEP_W'($urandom_range(0, 16));
            default: g.step = STEP_W'($urandom_range(0, 32'h30000));
        endcase
        return g;
    endfunction

    function automatic mix_cmd_t rand_cmd();
        mix_cmd_t c;
        int p;
        c.vidx = 3'($urandom);
        c.addr = ($urandom_range(0, 1) == 0) ? 18'($urandom_range(0, LOW_WORDS - 1))
                                             : 18'($urandom);
        c.sval = 16'($urandom);
        c.rgn = rand_region();
        c.intro = 1'($urandom_range(0, 1));
        p = $urandom_range(0, 99);
        if (p < 35)      c.cmd = CMD_TICK;
        else if (p < 43) c.cmd = CMD_WRITE_SAMPLE;
        else if (p < 58) c.cmd = CMD_START_EFFECT;
        else if (p < 66) c.cmd = CMD_STOP_EFFECT;
        else if (p < 76) c.cmd = CMD_START_SPEAKER;
        else if (p < 82) c.cmd = CMD_STOP_SPEAKER;
        else if (p < 87) c.cmd = CMD_SET_LOOP;
        else if (p < 92) c.cmd = CMD_START_MUSIC;
        else if (p < 95) c.cmd = CMD_STOP_MUSIC;
        else             c.cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        return c;
    endfunction

    task automatic issue(mix_cmd_t c);
        command <= c.cmd;
        voice_index <= c.vidx;
        mem_address <= c.addr;
        sample_value <= c.sval;
        region_start <= c.rgn.start;
        region_frames <= c.rgn.frames;
        region_stereo <= c.rgn.stereo;
        rate_step <= c.rgn.step;
        has_intro <= c.intro;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        model_command(c);
        if (!no_idle && $urandom_range(0, 99) < 29)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (frames_due.size() != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_reg(cfg_idx_t idx, int unsigned val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[GAIN_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_MUSIC_GAIN:   gain_music = val;
            CFG_EFFECT_GAIN:  gain_effect = val;
            CFG_SPEAKER_GAIN: gain_speaker = val;
            CFG_DECIMATE:     decim_on = val[0];
            CFG_STOP_MUSIC:   music_stop_end = val[0];
            default:          ;
        endcase
    endtask

    task automatic set_all(int unsigned mg, int unsigned eg, int unsigned sg, bit dm, bit sm);
        set_reg(CFG_MUSIC_GAIN, mg);
        set_reg(CFG_EFFECT_GAIN, eg);
        set_reg(CFG_SPEAKER_GAIN, sg);
        set_reg(CFG_DECIMATE, dm);
        set_reg(CFG_STOP_MUSIC, sm);
    endtask

    // result checker, results cannot be held off
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (frames_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected frame L=%0d R=%0d", left_sum, right_sum);
            end
            else
            begin
                if (frames_due[0].left !== left_sum || frames_due[0].right !== right_sum)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("frame mismatch: expected L=%0d R=%0d got L=%0d R=%0d",
                                 frames_due[0].left, frames_due[0].right, left_sum, right_sum);
                end
                void'(frames_due.pop_front());
            end
        end
    end

    // watchdog on transfers in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n || cfg_write)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        dir_row_t rows[$];
        mix_cmd_t c;
        int n_before;
        int n_frames;

        for (int i = 0; i < SAMPLE_WORDS; i++)
        begin
            pcm_mem[i] = '0;
        end
        model_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the words that regions may read
        for (int i = 0; i < LOW_WORDS + 64; i++)
        begin
            c = mk(CMD_WRITE_SAMPLE, 0, 0, 0, 0);
            c.addr = 18'((i < LOW_WORDS) ? i : WRAP_BASE + i - LOW_WORDS);
            c.sval = 16'($urandom);
            issue(c);
        end

        // directed table
        rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0), 1, 0, 0});
        c = mk(CMD_WRITE_SAMPLE, 0, 0, 0, 0); c.addr = 100; c.sval = 16'sh7FFF;
        rows.push_back('{c, 0, 0, 0});
        c.addr = 101; c.sval = -16'sh8000;
        rows.push_back('{c, 0, 0, 0});
        c = mk(CMD_START_SPEAKER, 100, 1, 0, 32'h10000); c.vidx = 3'd7;
        rows.push_back('{c, 0, 0, 0});
        rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0), 1, 8388352, 8388352});
        rows.push_back('{mk(CMD_START_EFFECT, 101, 1, 0, 32'h10000), 0, 0, 0});
        rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0), 1, -8388608, -8388608});
        rows.push_back('{mk(CMD_START_EFFECT, 100, 1, 0, 32'h10000), 0, 0, 0});
        rows.push_back('{mk(CMD_START_EFFECT, 100, 1, 0, 32'h10000), 0, 0, 0});
        rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0), 1, 8388607, 8388607});
        rows.push_back('{mk(CMD_START_EFFECT, 100, 1, 1, 0), 0, 0, 0});
        rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0), 1, 8388352, -8388608});
        rows.push_back('{mk(CMD_STOP_EFFECT, 100, 0, 0, 0), 0, 0, 0});
        rows.push_back('{mk(CMD_STOP_EFFECT, 77, 0, 0, 0), 0, 0, 0});
        rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0), 1, 0, 0});
        rows.push_back('{mk(CMD_UNUSED_LO, 0, 0, 0, 0), 0, 0, 0});
        rows.push_back('{mk(CMD_UNUSED_HI, 0, 0, 0, 0), 0, 0, 0});
        rows.push_back('{mk(CMD_START_MUSIC, 0, 0, 0, 0), 0, 0, 0});
        rows.push_back('{mk(CMD_SET_LOOP, SAMPLE_WORDS - 1, 3, 1, 32'h8000), 0, 0, 0});
        c = mk(CMD_START_MUSIC, 200, 0, 1, 32'hFFFFFF); c.intro = 1'b1;
        rows.push_back('{c, 0, 0, 0});
        rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0), 0, 0, 0});
        rows.push_back('{mk(CMD_START_EFFECT, 0, 262144, 1, 32'hFFFFFF), 0, 0, 0});
        c = mk(CMD_START_SPEAKER, 5, 0, 0, 0); c.vidx = 3'd0;
        rows.push_back('{c, 0, 0, 0});
        c = mk(CMD_START_SPEAKER, 262143, 1, 0, 1); c.vidx = 3'd0;
        rows.push_back('{c, 0, 0, 0});
        rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0), 0, 0, 0});
        rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0), 0, 0, 0});
        rows.push_back('{mk(CMD_STOP_EFFECT, 0, 0, 0, 0), 0, 0, 0});
        c = mk(CMD_STOP_SPEAKER, 0, 0, 0, 0); c.vidx = 3'd0;
        rows.push_back('{c, 0, 0, 0});
        rows.push_back('{mk(CMD_STOP_MUSIC, 0, 0, 0, 0), 0, 0, 0});
        rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0), 0, 0, 0});

        foreach (rows[i])
        begin
            n_before = frames_due.size();
            issue(rows[i].c);
            if (rows[i].known && frames_due.size() == n_before + 1)
            begin
                frames_due[n_before].left = OUT_W'(rows[i].left);
                frames_due[n_before].right = OUT_W'(rows[i].right);
            end
        end
        drain();

        // random phases across register settings
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_all(256, 256, 256, 1'b0, 1'b0);
                1: set_all(0, 0, 0, 1'b1, 1'b1);
                2: set_all(255, 1, 128, 1'b1, 1'b0);
                default: set_all($urandom_range(0, 256), $urandom_range(0, 256),
                                 $urandom_range(0, 256), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
            endcase
            n_frames = 0;
            for (int k = 0; k < 130; k++)
            begin
                no_idle = (ph == 1 && k >= 30 && k < 110);
                issue(rand_cmd());
            end
            no_idle = 1'b0;
            if (ph == 2)
            begin
                // exhaust the effect slots, then release some of them
                for (int k = 0; k < 70; k++)
                begin
                    c = mk(CMD_START_EFFECT, $urandom_range(0, 31) * 16, 200, 0, 0);
                    issue(c);
                end
                for (int k = 0; k < 3; k++)
                begin
                    issue(mk(CMD_TICK, 0, 0, 0, 0));
                end
                for (int k = 0; k < 40; k++)
                begin
                    issue(mk(CMD_STOP_EFFECT, $urandom_range(0, 31) * 16, 0, 0, 0));
                    issue(mk(CMD_TICK, 0, 0, 0, 0));
                end
            end
            drain();
        end

        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // leftover expectations are caught: drain only returns once the queue is empty

endmodule

`default_nettype wire
